>>> rtl/core/dfs_topological_sort_core_defines.svh
// Assertion macros used by the topological sort core RTL.
`ifndef DFS_TOPOLOGICAL_SORT_CORE_DEFINES_SVH
`define DFS_TOPOLOGICAL_SORT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst is high.
`define DTSC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtsc assertion failed");
// Next-cycle implication, sampled on clk, off while rst is high.
`define DTSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtsc assertion failed");
`else
`define DTSC_ASSERT_IMPL(lbl, ante, cons)
`define DTSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/dtsc_pkg.sv
// Types and constants of the topological sort core.
`timescale 1ns / 1ps
package dtsc_pkg;

  localparam logic [1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [1:0] OP_RUN      = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  localparam logic [6:0] VCOUNT_RESET = 7'd64;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] source_vertex;
    logic [5:0] target_vertex;
  } in_item_t;

  typedef struct packed {
    logic [5:0] out_vertex;
    logic       cycle_marker;
    logic       last_item;
  } out_item_t;

endpackage

>>> rtl/core/dtsc_if.sv
// Valid/ready channel interfaces: command, result and configuration.
`timescale 1ns / 1ps
interface dtsc_in_if;
  logic              valid;
  logic              ready;
  dtsc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dtsc_out_if;
  logic               valid;
  logic               ready;
  dtsc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dtsc_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/dfs_topological_sort_core.sv
// Top level: edge store, depth-first walk sequencer and result emission.
// Add edge: ADD1 stores it; ADD2 links it to the old tail if the list had edges.
// Clear acts as it is taken. Run: roots are checked in turn; a vertex entered
// reads its list head and its edges are scanned; a finished vertex is recorded.
// Results go out one by one, held while the output is full; one op at a time.
// Reset (sync, active high): empty graph, vertex_count 64; no memory sweep.
`timescale 1ns / 1ps
`include "dfs_topological_sort_core_defines.svh"
module dfs_topological_sort_core #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input logic        clk,
  input logic        rst,
  dtsc_in_if.sink    cmd,
  dtsc_cfg_if.sink   cfg,
  dtsc_out_if.source result
);
  import dtsc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int NW = EW + 1;
  localparam int EC = $clog2(MAX_EDGES + 1);
  localparam int LW = 2 * EW;
  localparam int SW = VW + NW;
  localparam logic [NW-1:0] EMPTY_LINK = {1'b1, {EW{1'b0}}};

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADD1    = 4'd1;
  localparam logic [3:0] S_ADD2    = 4'd2;
  localparam logic [3:0] S_ROOT    = 4'd3;
  localparam logic [3:0] S_LHEAD   = 4'd4;
  localparam logic [3:0] S_STEP    = 4'd5;
  localparam logic [3:0] S_EDGE    = 4'd6;
  localparam logic [3:0] S_POP     = 4'd7;
  localparam logic [3:0] S_EMIT_RD = 4'd8;
  localparam logic [3:0] S_EMIT_LD = 4'd9;

  logic [3:0]           state;
  logic [6:0]           vertex_count;
  logic [CW-1:0]        vc_run;
  logic [MAX_VERTICES-1:0] list_valid;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] on_path;
  logic [EC-1:0]        edge_count;
  logic [VW-1:0]        src_reg;
  logic [5:0]           dst_reg;
  logic [EW-1:0]        idx_reg;
  logic [EW-1:0]        tail_reg;
  logic [CW-1:0]        root;
  logic [CW-1:0]        depth;
  logic [CW-1:0]        finished;
  logic [CW-1:0]        emit_k;
  logic                 cycle;
  logic [VW-1:0]        top_u;
  logic [NW-1:0]        top_cur;

  // memory ports
  logic          list_we;
  logic [VW-1:0] list_waddr, list_raddr;
  logic [LW-1:0] list_wdata, list_rdata;
  logic          tgt_we;
  logic [5:0]    tgt_rdata;
  logic          nxt_we;
  logic [EW-1:0] nxt_waddr;
  logic [NW-1:0] nxt_wdata, nxt_rdata;
  logic          stk_we;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;
  logic          fin_we;
  logic [VW-1:0] fin_raddr;
  logic [VW-1:0] fin_rdata;

  logic          cmd_xfer;
  logic          src_ok;
  logic          store_full;
  logic [5:0]    edge_dst;
  logic [VW-1:0] edge_tv;
  logic          edge_out_of_use;
  logic [CW-1:0] total;
  logic          emit_last;
  logic          emit_marker;
  logic          out_load;
  logic          out_free;
  out_item_t     out_item;

  assign cmd.ready  = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign cmd_xfer   = cmd.valid && cmd.ready;
  assign src_ok     = 32'(cmd.data.source_vertex) < MAX_VERTICES;
  assign store_full = 32'(edge_count) >= MAX_EDGES;

  assign edge_dst        = tgt_rdata;
  assign edge_tv         = VW'(edge_dst);
  assign edge_out_of_use = 32'(edge_dst) >= 32'(vc_run);

  assign total       = cycle ? finished + CW'(1) : finished;
  assign emit_last   = (emit_k == total - CW'(1));
  assign emit_marker = cycle && (emit_k == finished);

  // ---- memory port steering ----
  always_comb begin
    list_we    = (state == S_ADD1);
    list_waddr = src_reg;
    list_wdata = list_valid[src_reg] ? {list_rdata[LW-1:EW], idx_reg} : {idx_reg, idx_reg};
    case (state)
      S_IDLE:  list_raddr = VW'(cmd.data.source_vertex);
      S_ROOT:  list_raddr = VW'(root);
      S_EDGE:  list_raddr = edge_tv;
      default: list_raddr = top_u;
    endcase

    tgt_we    = (state == S_ADD1);
    nxt_we    = (state == S_ADD1) || (state == S_ADD2);
    nxt_waddr = (state == S_ADD2) ? tail_reg : idx_reg;
    nxt_wdata = (state == S_ADD2) ? {1'b0, idx_reg} : EMPTY_LINK;

    stk_we    = (state == S_EDGE) && !edge_out_of_use && !on_path[edge_tv] && !visited[edge_tv];
    stk_waddr = VW'(depth - CW'(1));
    stk_wdata = {top_u, nxt_rdata};
    stk_raddr = VW'(depth - CW'(2));

    fin_we    = (state == S_STEP) && top_cur[NW-1];
    fin_raddr = cycle ? VW'(emit_k) : VW'(finished - emit_k - CW'(1));
  end

  dtsc_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_list_ram (
    .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
    .raddr(list_raddr), .rdata(list_rdata)
  );

  dtsc_ram #(.WIDTH(6), .DEPTH(MAX_EDGES)) u_target_ram (
    .clk(clk), .we(tgt_we), .waddr(idx_reg), .wdata(dst_reg),
    .raddr(top_cur[EW-1:0]), .rdata(tgt_rdata)
  );

  dtsc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(top_cur[EW-1:0]), .rdata(nxt_rdata)
  );

  dtsc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  dtsc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_finish_ram (
    .clk(clk), .we(fin_we), .waddr(VW'(finished)), .wdata(top_u),
    .raddr(fin_raddr), .rdata(fin_rdata)
  );

  // ---- result stage ----
  assign out_load = (state == S_EMIT_LD) && out_free;

  always_comb begin
    if (emit_marker) begin
      out_item.out_vertex   = 6'd0;
      out_item.cycle_marker = 1'b1;
    end else begin
      out_item.out_vertex   = 6'(fin_rdata);
      out_item.cycle_marker = 1'b0;
    end
    out_item.last_item = emit_last;
  end

  dtsc_out_stage u_out_stage (
    .clk(clk), .rst(rst), .load(out_load), .item(out_item),
    .free(out_free), .result(result)
  );

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      vertex_count <= cfg.data;
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      list_valid <= '0;
      visited    <= '0;
      on_path    <= '0;
      edge_count <= '0;
      vc_run     <= '0;
      root       <= '0;
      depth      <= '0;
      finished   <= '0;
      emit_k     <= '0;
      cycle      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_xfer) begin
            case (cmd.data.operation)
              OP_ADD_EDGE: begin
                if (src_ok && !store_full) begin
                  src_reg <= VW'(cmd.data.source_vertex);
                  dst_reg <= cmd.data.target_vertex;
                  idx_reg <= EW'(edge_count);
                  state   <= S_ADD1;
                end
              end
              OP_RUN: begin
                vc_run   <= (32'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                              : CW'(vertex_count);
                visited  <= '0;
                on_path  <= '0;
                root     <= '0;
                depth    <= '0;
                finished <= '0;
                cycle    <= 1'b0;
                state    <= S_ROOT;
              end
              OP_CLEAR: begin
                list_valid <= '0;
                edge_count <= '0;
              end
              default: ;
            endcase
          end
        end
        S_ADD1: begin
          list_valid[src_reg] <= 1'b1;
          tail_reg            <= list_rdata[EW-1:0];
          edge_count          <= edge_count + EC'(1);
          state               <= list_valid[src_reg] ? S_ADD2 : S_IDLE;
        end
        S_ADD2: begin
          state <= S_IDLE;
        end
        S_ROOT: begin
          if (root >= vc_run) begin
            emit_k <= '0;
            state  <= (finished == '0) ? S_IDLE : S_EMIT_RD;
          end else if (visited[VW'(root)]) begin
            root <= root + CW'(1);
          end else begin
            visited[VW'(root)] <= 1'b1;
            on_path[VW'(root)] <= 1'b1;
            top_u              <= VW'(root);
            depth              <= CW'(1);
            state              <= S_LHEAD;
          end
        end
        S_LHEAD: begin
          top_cur <= list_valid[top_u] ? {1'b0, list_rdata[LW-1:EW]} : EMPTY_LINK;
          state   <= S_STEP;
        end
        S_STEP: begin
          if (top_cur[NW-1]) begin
            // vertex done: record it and drop back to its parent or on to the next root
            on_path[top_u] <= 1'b0;
            finished       <= finished + CW'(1);
            depth          <= depth - CW'(1);
            if (depth == CW'(1)) begin
              root  <= root + CW'(1);
              state <= S_ROOT;
            end else begin
              state <= S_POP;
            end
          end else begin
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          top_cur <= nxt_rdata;
          if (edge_out_of_use) begin
            state <= S_STEP;
          end else if (on_path[edge_tv]) begin
            cycle  <= 1'b1;
            emit_k <= '0;
            state  <= S_EMIT_RD;
          end else if (!visited[edge_tv]) begin
            visited[edge_tv] <= 1'b1;
            on_path[edge_tv] <= 1'b1;
            top_u            <= edge_tv;
            depth            <= depth + CW'(1);
            state            <= S_LHEAD;
          end else begin
            state <= S_STEP;
          end
        end
        S_POP: begin
          top_u   <= stk_rdata[SW-1:NW];
          top_cur <= stk_rdata[NW-1:0];
          state   <= S_STEP;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              emit_k <= emit_k + CW'(1);
              state  <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---- checks ----
  `DTSC_ASSERT_IMPL(a_edge_count_bound, 1'b1, 32'(edge_count) <= MAX_EDGES)
  `DTSC_ASSERT_IMPL(a_depth_bound, 1'b1, depth <= vc_run)
  `DTSC_ASSERT_NEXT(a_run_starts, cmd_xfer && (cmd.data.operation == OP_RUN), state == S_ROOT)
  `DTSC_ASSERT_IMPL(a_path_matches_depth, state == S_STEP, $countones(on_path) == 32'(depth))

endmodule

>>> rtl/core/dtsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dtsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/dtsc_out_stage.sv
// Output register stage: holds one result until the sink takes it.
`timescale 1ns / 1ps
module dtsc_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  dtsc_pkg::out_item_t item,
  output logic                free,
  dtsc_out_if.source          result
);
  import dtsc_pkg::*;

  logic      valid;
  out_item_t data;

  assign free         = !valid || result.ready;
  assign result.valid = valid;
  assign result.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= item;
    end
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the depth-first topological sort core.
`timescale 1ns / 1ps
module testbench;
  import dtsc_pkg::*;

  localparam int NV = 64;
  localparam int NE = 256;
  localparam logic [8:0] NO_EDGE = 9'd256;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtsc_in_if  cmd_ch ();
  dtsc_cfg_if cfg_ch ();
  dtsc_out_if res_ch ();

  dfs_topological_sort_core dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .cfg(cfg_ch), .result(res_ch)
  );

  always #2 clk = ~clk;

  // Shadow graph and register
  logic [6:0] vertex_count;
  logic [8:0] adj_head [NV];
  logic [8:0] adj_tail [NV];
  logic [5:0] edge_dst [NE];
  logic [8:0] edge_link [NE];
  logic [8:0] edges_stored;
  out_item_t  order_q [$];
  out_item_t  want;

  bit idle_on;
  int stall_left = 0;
  int errors = 0;
  int results_seen = 0;
  int cycles_seen = 0;
  int runs_sent, edges_sent;

  function automatic void graph_clear();
    for (int i = 0; i < NV; i++) begin
      adj_head[i] = NO_EDGE;
      adj_tail[i] = NO_EDGE;
    end
    edges_stored = '0;
  endfunction

  function automatic void graph_add(logic [5:0] src, logic [5:0] dst);
    if (edges_stored >= NE) return;
    edge_dst[edges_stored[7:0]] = dst;
    edge_link[edges_stored[7:0]] = NO_EDGE;
    if (adj_tail[src] == NO_EDGE) adj_head[src] = edges_stored;
    else edge_link[adj_tail[src][7:0]] = edges_stored;
    adj_tail[src] = edges_stored;
    edges_stored = edges_stored + 9'd1;
  endfunction

  // Walks the shadow graph and queues the ordering the core should emit.
  function automatic void predict_sort();
    int vc, done, depth, top;
    logic [5:0] finished_v [NV];
    logic seen [NV];
    logic on_path [NV];
    logic [5:0] stk_vtx [NV];
    logic [8:0] stk_cur [NV];
    logic [5:0] u, t;
    logic [8:0] e;
    bit cycle;
    out_item_t item;
    vc = (vertex_count > NV) ? NV : int'(vertex_count);
    done = 0;
    cycle = 1'b0;
    for (int i = 0; i < NV; i++) begin
      seen[i] = 1'b0;
      on_path[i] = 1'b0;
    end
    for (int root = 0; root < vc && !cycle; root++) begin
      if (seen[root]) continue;
      seen[root] = 1'b1;
      on_path[root] = 1'b1;
      stk_vtx[0] = 6'(root);
      stk_cur[0] = adj_head[root];
      depth = 1;
      while (depth > 0) begin
        top = depth - 1;
        u = stk_vtx[top];
        e = stk_cur[top];
        if (e >= NE) begin
          on_path[u] = 1'b0;
          if (done < NV) begin
            finished_v[done] = u;
            done++;
          end
          depth--;
        end else begin
          t = edge_dst[e[7:0]];
          stk_cur[top] = edge_link[e[7:0]];
          // targets outside the active range are skipped
          if (t < vc) begin
            if (on_path[t]) begin
              cycle = 1'b1;
              break;
            end
            if (!seen[t] && depth < NV) begin
              seen[t] = 1'b1;
              on_path[t] = 1'b1;
              stk_vtx[depth] = t;
              stk_cur[depth] = adj_head[t];
              depth++;
            end
          end
        end
      end
    end
    if (cycle) begin
      for (int i = 0; i < done; i++) begin
        item.out_vertex = finished_v[i];
        item.cycle_marker = 1'b0;
        item.last_item = 1'b0;
        order_q.insert(order_q.size(), item);
      end
      item.out_vertex = 6'd0;
      item.cycle_marker = 1'b1;
      item.last_item = 1'b1;
      order_q.insert(order_q.size(), item);
    end else begin
      for (int i = done; i > 0; i--) begin
        item.out_vertex = finished_v[i - 1];
        item.cycle_marker = 1'b0;
        item.last_item = (i == 1);
        order_q.insert(order_q.size(), item);
      end
    end
  endfunction

  // Result sink with random stall bursts
  always @(negedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      res_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (res_ch.data.cycle_marker) cycles_seen++;
      if (order_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual vertex=%0d cycle=%0b last=%0b",
                 $time, res_ch.data.out_vertex, res_ch.data.cycle_marker,
                 res_ch.data.last_item);
      end else begin
        want = order_q.pop_front();
        if (res_ch.data.out_vertex !== want.out_vertex ||
            res_ch.data.cycle_marker !== want.cycle_marker ||
            res_ch.data.last_item !== want.last_item) begin
          errors++;
          $display("%0t: result mismatch, expected vertex=%0d cycle=%0b last=%0b,",
                   $time, want.out_vertex, want.cycle_marker, want.last_item,
                   " actual vertex=%0d cycle=%0b last=%0b", res_ch.data.out_vertex,
                   res_ch.data.cycle_marker, res_ch.data.last_item);
        end
      end
    end
  end

  // Valid stays high across back-to-back commands; lowered only on a gap.
  task automatic send_cmd(input logic [1:0] op, input logic [5:0] src, input logic [5:0] dst);
    int gap;
    in_item_t cmd;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    cmd.operation = op;
    cmd.source_vertex = src;
    cmd.target_vertex = dst;
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= cmd;
    do @(posedge clk); while (!cmd_ch.ready);
    case (op)
      OP_ADD_EDGE: begin
        graph_add(src, dst);
        edges_sent++;
      end
      OP_RUN: begin
        predict_sort();
        runs_sent++;
      end
      OP_CLEAR: graph_clear();
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    @(negedge clk) cmd_ch.valid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
    // an add or an empty run may still be finishing
    repeat (16) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [6:0] value);
    wait_quiet();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    vertex_count = value;
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_cmd(OP_RUN, 6'd0, 6'd0);
  endtask

  task automatic test_small_orders();
    write_vertex_count(7'd6);
    send_cmd(OP_CLEAR, 6'd0, 6'd0);
    send_cmd(OP_ADD_EDGE, 6'd0, 6'd1);
    send_cmd(OP_ADD_EDGE, 6'd1, 6'd2);
    send_cmd(OP_ADD_EDGE, 6'd3, 6'd1);
    send_cmd(OP_ADD_EDGE, 6'd2, 6'd5);
    send_cmd(OP_ADD_EDGE, 6'd0, 6'd4);
    send_cmd(OP_RUN, 6'd63, 6'd63);
  endtask

  task automatic test_cycles();
    write_vertex_count(7'd4);
    send_cmd(OP_CLEAR, 6'd0, 6'd0);
    send_cmd(OP_ADD_EDGE, 6'd0, 6'd1);
    send_cmd(OP_ADD_EDGE, 6'd2, 6'd2);
    send_cmd(OP_ADD_EDGE, 6'd1, 6'd3);
    send_cmd(OP_ADD_EDGE, 6'd3, 6'd63);
    send_cmd(OP_RUN, 6'd0, 6'd0);
    // cycle reachable from the first root: only the marker comes out
    send_cmd(OP_CLEAR, 6'd63, 6'd63);
    send_cmd(OP_ADD_EDGE, 6'd0, 6'd1);
    send_cmd(OP_ADD_EDGE, 6'd1, 6'd2);
    send_cmd(OP_ADD_EDGE, 6'd2, 6'd0);
    send_cmd(OP_UNUSED, 6'd63, 6'd63);
    send_cmd(OP_RUN, 6'd0, 6'd0);
  endtask

  task automatic test_vertex_count_limits();
    write_vertex_count(7'd0);
    send_cmd(OP_RUN, 6'd0, 6'd0);
    write_vertex_count(7'd127);
    send_cmd(OP_CLEAR, 6'd0, 6'd0);
    send_cmd(OP_ADD_EDGE, 6'd63, 6'd0);
    send_cmd(OP_RUN, 6'd0, 6'd0);
    write_vertex_count(7'd1);
    send_cmd(OP_RUN, 6'd0, 6'd0);
  endtask

  // Fill the store with forward edges, then try a self loop and a back edge.
  task automatic test_full_edge_store();
    logic [5:0] a, b;
    write_vertex_count(7'd64);
    send_cmd(OP_CLEAR, 6'd0, 6'd0);
    for (int i = 0; i < NE; i++) begin
      a = 6'($urandom_range(0, 62));
      b = 6'($urandom_range(a + 1, 63));
      send_cmd(OP_ADD_EDGE, a, b);
    end
    send_cmd(OP_ADD_EDGE, 6'd5, 6'd5);
    send_cmd(OP_ADD_EDGE, 6'd63, 6'd0);
    send_cmd(OP_RUN, 6'd0, 6'd0);
  endtask

  task automatic test_random_graphs(input int budget, input bit allow_idle);
    int sent, k, mode, span, vcs;
    logic [6:0] vc_pick;
    logic [5:0] a, b, tmp;
    sent = 0;
    while (sent < budget) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 11))
          0: vc_pick = 7'd64;
          1: vc_pick = 7'($urandom_range(65, 127));
          2: vc_pick = 7'd0;
          3: vc_pick = 7'd1;
          default: vc_pick = 7'($urandom_range(2, 16));
        endcase
        write_vertex_count(vc_pick);
      end
      vcs = (vertex_count > NV) ? NV : int'(vertex_count);
      span = (vcs == 0) ? NV : vcs;
      // 0: acyclic, 1: acyclic plus one back edge, 2: anything goes
      mode = $urandom_range(0, 2);
      if ($urandom_range(0, 3) != 0) begin
        send_cmd(OP_CLEAR, 6'($urandom), 6'($urandom));
        sent++;
      end
      k = $urandom_range(0, (3 * span > 30) ? 30 : 3 * span);
      a = 6'd0;
      b = 6'd0;
      for (int i = 0; i < k; i++) begin
        if (mode == 2) begin
          a = 6'($urandom);
          b = 6'($urandom);
        end else begin
          a = 6'($urandom_range(0, span - 1));
          b = 6'($urandom_range(0, span - 1));
          if (a == b) b = a + 6'd1;
          if (a > b) begin
            tmp = a;
            a = b;
            b = tmp;
          end
        end
        if ($urandom_range(0, 9) == 0) send_cmd(OP_UNUSED, 6'($urandom), 6'($urandom));
        send_cmd(OP_ADD_EDGE, a, b);
        sent++;
      end
      if (mode == 1 && k > 0) begin
        send_cmd(OP_ADD_EDGE, b, a);
        sent++;
      end
      send_cmd(OP_RUN, 6'($urandom), 6'($urandom));
      sent++;
    end
  endtask

  task automatic finish_run();
    int waited;
    int missing;
    @(negedge clk) cmd_ch.valid <= 1'b0;
    waited = 0;
    while (order_q.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    missing = order_q.size();
    if (missing != 0) begin
      $display("%0t: %0d expected results never arrived", $time, missing);
    end
    $display("Covered %0d edge adds and %0d sort runs over vertex counts 0 to 127,",
             edges_sent, runs_sent, " with a full edge store, self loops and cycles.");
    $display("Checked %0d results (%0d cycle markers), %0d failures.",
             results_seen, cycles_seen, errors + ((missing != 0) ? 1 : 0));
    if (errors == 0 && missing == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  endtask

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    idle_on = 1'b1;
    runs_sent = 0;
    edges_sent = 0;
    vertex_count = VCOUNT_RESET;
    graph_clear();
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_reset_state();
    test_small_orders();
    test_cycles();
    test_vertex_count_limits();
    test_full_edge_store();
    test_random_graphs(80, 1'b1);
    test_random_graphs(25, 1'b0);
    finish_run();
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
